@@ design/assert_macros.svh @@
// Assertion macros for the integrator design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VVLS_ASSERT_IMPLY(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("integrator assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define VVLS_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("integrator assertion failed");

`endif

@@ design/vvls_pkg.sv @@
// Shared constants, types and helper functions of the velocity Verlet integrator.
package vvls_pkg;

    localparam int WORD_BITS     = 32;
    localparam int FRAC_BITS     = 16;
    localparam int DIMS          = 3;
    localparam int NUM_TYPES_DEF = 16;
    localparam int TYPE_W        = 4;
    localparam int INDEX_W       = 16;
    localparam int STEP_W        = 31;
    localparam int LIMSQ_W       = 63;
    localparam int MASS_W        = 31;
    localparam int KPROD_W       = 62;
    localparam int WIDE_W        = 64;
    localparam int ROOT_W        = WIDE_W / 2;
    localparam int CFG_ADDR_W    = 3;
    localparam int CFG_DATA_W    = 63;
    localparam int S_TDATA_W     = 312;
    localparam int M_TDATA_W     = 208;
    localparam int S_TUSER_W     = 1;
    localparam int M_TUSER_W     = 2;

    localparam logic [MASS_W-1:0] MASS_ONE = MASS_W'(1) << FRAC_BITS;
    localparam logic signed [WIDE_W-1:0] SAT_HI = 64'sd2147483647;
    localparam logic signed [WIDE_W-1:0] SAT_LO = -64'sd2147483648;

    // Configuration register indexes.
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_KICK_STEP  = 3'd0,
        CFG_DRIFT_STEP = 3'd1,
        CFG_LIMIT_SQ   = 3'd2,
        CFG_LIMIT_EN   = 3'd3,
        CFG_THREE_DIMS = 3'd4,
        CFG_MASS_SLOT  = 3'd5,
        CFG_MASS_VALUE = 3'd6
    } cfg_reg_t;

    typedef logic [DIMS-1:0][WORD_BITS-1:0] vec_t;

    // Atom data that rides alongside the kick dividers.
    typedef struct packed {
        logic                op;
        logic [INDEX_W-1:0]  idx;
        vec_t                pos;
        vec_t                vel;
        logic [DIMS-1:0]     neg;
    } kick_side_t;

    // Atom data after the kick, up to the output.
    typedef struct packed {
        logic                op;
        logic [INDEX_W-1:0]  idx;
        vec_t                pos;
        vec_t                vel;
        logic                sat;
        logic                over;
    } atom_side_t;

    typedef struct packed {
        logic                 sat;
        logic [WORD_BITS-1:0] val;
    } sat_res_t;

    // Magnitude of a signed word; the most negative value maps to 2^31.
    function automatic logic [WORD_BITS-1:0] mag_w(input logic [WORD_BITS-1:0] v);
        return v[WORD_BITS-1] ? (~v + WORD_BITS'(1)) : v;
    endfunction

    // Adds a signed magnitude to a word and clamps to the signed word range.
    function automatic sat_res_t sat_add(input logic [WORD_BITS-1:0] v,
                                         input logic [KPROD_W-1:0] m,
                                         input logic neg);
        logic signed [WIDE_W-1:0] a;
        logic signed [WIDE_W-1:0] b;
        logic signed [WIDE_W-1:0] s;
        sat_res_t r;
        a = $signed({{(WIDE_W-WORD_BITS){v[WORD_BITS-1]}}, v});
        b = $signed({{(WIDE_W-KPROD_W){1'b0}}, m});
        s = neg ? (a - b) : (a + b);
        if (s > SAT_HI) begin
            r.sat = 1'b1;
            r.val = SAT_HI[WORD_BITS-1:0];
        end else if (s < SAT_LO) begin
            r.sat = 1'b1;
            r.val = SAT_LO[WORD_BITS-1:0];
        end else begin
            r.sat = 1'b0;
            r.val = s[WORD_BITS-1:0];
        end
        return r;
    endfunction

endpackage

@@ design/vvls_delay.sv @@
// Enabled delay line that carries a valid bit and a payload word.
module vvls_delay #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         en,
    input  logic         in_valid,
    input  logic [W-1:0] in_data,
    output logic         out_valid,
    output logic [W-1:0] out_data
);

    logic [DEPTH-1:0] valid_reg;
    logic [W-1:0]     data_reg [DEPTH];

    // Valid bits are control state and clear on reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg[0] <= in_valid;
            for (int i = 1; i < DEPTH; i++) begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    // Payload shifts without reset.
    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg[0] <= in_data;
            for (int i = 1; i < DEPTH; i++) begin
                data_reg[i] <= data_reg[i-1];
            end
        end
    end

    assign out_valid = valid_reg[DEPTH-1];
    assign out_data  = data_reg[DEPTH-1];

endmodule

@@ design/vvls_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
module vvls_div #(
    parameter int NW = 62,
    parameter int DW = 31
) (
    input  logic          aclk,
    input  logic          en,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic [NW-1:0] quotient
);

    logic [DW-1:0] rem_reg  [NW];
    logic [NW-1:0] nq_reg   [NW];
    logic [DW-1:0] dv_reg   [NW];
    logic [DW-1:0] rem_next [NW];
    logic [NW-1:0] nq_next  [NW];
    logic [DW-1:0] dv_next  [NW];

    // Each stage shifts in one dividend bit and subtracts the divisor when it fits.
    always_comb begin
        logic [DW-1:0] rem_in;
        logic [NW-1:0] nq_in;
        logic [DW-1:0] dv_in;
        logic [DW:0]   trial;
        logic          ge;
        for (int s = 0; s < NW; s++) begin
            if (s == 0) begin
                rem_in = '0;
                nq_in  = dividend;
                dv_in  = divisor;
            end else begin
                rem_in = rem_reg[s-1];
                nq_in  = nq_reg[s-1];
                dv_in  = dv_reg[s-1];
            end
            trial = {rem_in, nq_in[NW-1]};
            ge    = (trial >= {1'b0, dv_in});
            rem_next[s] = ge ? DW'(trial - {1'b0, dv_in}) : trial[DW-1:0];
            nq_next[s]  = {nq_in[NW-2:0], ge};
            dv_next[s]  = dv_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int s = 0; s < NW; s++) begin
                rem_reg[s] <= rem_next[s];
                nq_reg[s]  <= nq_next[s];
                dv_reg[s]  <= dv_next[s];
            end
        end
    end

    assign quotient = nq_reg[NW-1];

endmodule

@@ design/vvls_isqrt.sv @@
// Pipelined integer square root (floor), one root bit per stage.
module vvls_isqrt #(
    parameter int IW = 64
) (
    input  logic                aclk,
    input  logic                en,
    input  logic [IW-1:0]       radicand,
    output logic [IW/2-1:0]     root
);

    localparam int RW   = IW / 2;
    localparam int REMW = RW + 2;

    logic [REMW-1:0] rem_reg   [RW];
    logic [RW-1:0]   root_reg  [RW];
    logic [IW-1:0]   rest_reg  [RW];
    logic [REMW-1:0] rem_next  [RW];
    logic [RW-1:0]   root_next [RW];
    logic [IW-1:0]   rest_next [RW];

    // Each stage brings down two radicand bits and tries the next root bit.
    always_comb begin
        logic [REMW-1:0] rem_in;
        logic [RW-1:0]   root_in;
        logic [IW-1:0]   rest_in;
        logic [REMW+1:0] cur;
        logic [REMW+1:0] trial;
        logic            ge;
        for (int s = 0; s < RW; s++) begin
            if (s == 0) begin
                rem_in  = '0;
                root_in = '0;
                rest_in = radicand;
            end else begin
                rem_in  = rem_reg[s-1];
                root_in = root_reg[s-1];
                rest_in = rest_reg[s-1];
            end
            cur   = {rem_in, rest_in[IW-1:IW-2]};
            trial = (REMW+2)'({root_in, 2'b01});
            ge    = (cur >= trial);
            rem_next[s]  = ge ? REMW'(cur - trial) : REMW'(cur);
            root_next[s] = {root_in[RW-2:0], ge};
            rest_next[s] = {rest_in[IW-3:0], 2'b00};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int s = 0; s < RW; s++) begin
                rem_reg[s]  <= rem_next[s];
                root_reg[s] <= root_next[s];
                rest_reg[s] <= rest_next[s];
            end
        end
    end

    assign root = root_reg[RW-1];

endmodule

@@ design/velocity_verlet_limited_step.sv @@
// Velocity Verlet step with per-type mass, optional speed limit and saturation.
// One atom enters per clock cycle while the pipeline is not stalled; the
// depth is set by the kick dividers (62 stages), the two square roots (32
// stages) and the limit dividers (64 stages), plus nine arithmetic stages and
// the output register. The whole pipeline advances together, so a stall on the
// result side holds every stage and input requests wait until the held result
// is taken.
// Configuration writes belong to idle periods; mass table writes go through
// mass_slot then mass_value, and every table entry resets to 1.0.
`include "assert_macros.svh"

module velocity_verlet_limited_step
    import vvls_pkg::*;
#(
    parameter int NUM_TYPES = NUM_TYPES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Input channel.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // atom_index[15:0], atom_type[19:16], pos_x/y/z[115:20],
    // vel_x/y/z[211:116], force_x/y/z[307:212], zero fill[311:308]
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // operation[0]
    input  logic [S_TUSER_W-1:0]  s_tuser,
    // Result channel.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // out_index[15:0], new_pos_x/y/z[111:16], new_vel_x/y/z[207:112]
    output logic [M_TDATA_W-1:0]  m_tdata,
    // was_limited[0], saturated[1]
    output logic [M_TUSER_W-1:0]  m_tuser,
    // Configuration write port.
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int TYPE_IDX_W = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;

    // Configuration state.
    logic [STEP_W-1:0]  kick_step_reg;
    logic [STEP_W-1:0]  drift_step_reg;
    logic [LIMSQ_W-1:0] limit_sq_reg;
    logic               limit_en_reg;
    logic               three_dims_reg;
    logic [TYPE_W-1:0]  mass_slot_reg;
    logic [MASS_W-1:0]  mass_tab_reg [NUM_TYPES];

    logic [TYPE_IDX_W-1:0] type_map [1 << TYPE_W];

    logic adv;

    // Stage registers.
    logic                  s0_valid_reg, s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic                  s4_valid_reg, s5_valid_reg, s6_valid_reg, s7_valid_reg;
    logic                  s8_valid_reg;
    logic                  s0_op_reg;
    logic [INDEX_W-1:0]    s0_idx_reg;
    logic [TYPE_IDX_W-1:0] s0_type_reg;
    vec_t                  s0_pos_reg, s0_vel_reg, s0_frc_reg;

    kick_side_t            s1_side_reg, s1_side_next;
    logic [KPROD_W-1:0]    s1_kprod_reg [DIMS];
    logic [KPROD_W-1:0]    s1_kprod_next [DIMS];
    logic [MASS_W-1:0]     s1_mass_reg, s1_mass_next;

    logic                  kd_valid;
    kick_side_t            kd_side;
    logic [KPROD_W-1:0]    kq [DIMS];

    atom_side_t            s2_side_reg, s2_side_next;
    atom_side_t            s3_side_reg;
    logic [WIDE_W-1:0]     s3_sq_reg [DIMS];
    logic [WIDE_W-1:0]     s3_sq_next [DIMS];
    atom_side_t            s4_side_reg;
    logic [WIDE_W-1:0]     s4_vsq_reg;
    atom_side_t            s5_side_reg, s5_side_next;
    logic [WIDE_W-1:0]     s5_vsq_reg;

    logic                  sq_valid;
    atom_side_t            sq_side;
    logic [ROOT_W-1:0]     mag_root, lim_root;

    atom_side_t            s6_side_reg;
    logic [WIDE_W-1:0]     s6_prod_reg [DIMS];
    logic [WIDE_W-1:0]     s6_prod_next [DIMS];
    logic [ROOT_W-1:0]     s6_mag_reg;

    logic                  ld_valid;
    atom_side_t            ld_side;
    logic [WIDE_W-1:0]     lq [DIMS];

    atom_side_t            s7_side_reg, s7_side_next;
    atom_side_t            s8_side_reg;
    logic [KPROD_W-1:0]    s8_dp_reg [DIMS];
    logic [KPROD_W-1:0]    s8_dp_next [DIMS];

    logic                  m_tvalid_reg;
    logic [M_TDATA_W-1:0]  m_tdata_reg, m_tdata_next;
    logic [M_TUSER_W-1:0]  m_tuser_reg, m_tuser_next;

    // The pipeline moves whenever the output register is free or being emptied.
    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;

    // Atom type codes wrap onto the table.
    for (genvar g = 0; g < (1 << TYPE_W); g++) begin : g_type_map
        assign type_map[g] = TYPE_IDX_W'(g % NUM_TYPES);
    end

    // Configuration register writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kick_step_reg  <= '0;
            drift_step_reg <= '0;
            limit_sq_reg   <= '0;
            limit_en_reg   <= 1'b0;
            three_dims_reg <= 1'b1;
            mass_slot_reg  <= '0;
            for (int i = 0; i < NUM_TYPES; i++) begin
                mass_tab_reg[i] <= MASS_ONE;
            end
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_KICK_STEP:  kick_step_reg  <= cfg_wdata[STEP_W-1:0];
                CFG_DRIFT_STEP: drift_step_reg <= cfg_wdata[STEP_W-1:0];
                CFG_LIMIT_SQ:   limit_sq_reg   <= cfg_wdata[LIMSQ_W-1:0];
                CFG_LIMIT_EN:   limit_en_reg   <= cfg_wdata[0];
                CFG_THREE_DIMS: three_dims_reg <= cfg_wdata[0];
                CFG_MASS_SLOT:  mass_slot_reg  <= cfg_wdata[TYPE_W-1:0];
                CFG_MASS_VALUE: mass_tab_reg[type_map[mass_slot_reg]] <= cfg_wdata[MASS_W-1:0];
                default: ;
            endcase
        end
    end

    // Valid bits of the local stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
            s8_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            s0_valid_reg <= s_tvalid;
            s1_valid_reg <= s0_valid_reg;
            s2_valid_reg <= kd_valid;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= sq_valid;
            s7_valid_reg <= ld_valid;
            s8_valid_reg <= s7_valid_reg;
            m_tvalid_reg <= s8_valid_reg;
        end
    end

    // Kick numerator and mass lookup.
    always_comb begin
        s1_side_next.op  = s0_op_reg;
        s1_side_next.idx = s0_idx_reg;
        s1_side_next.pos = s0_pos_reg;
        s1_side_next.vel = s0_vel_reg;
        for (int d = 0; d < DIMS; d++) begin
            s1_side_next.neg[d] = s0_frc_reg[d][WORD_BITS-1];
            s1_kprod_next[d]    = KPROD_W'(kick_step_reg) * KPROD_W'(mag_w(s0_frc_reg[d]));
        end
        // A zero mass acts as one LSB.
        s1_mass_next = mass_tab_reg[s0_type_reg];
        if (s1_mass_next == '0) begin
            s1_mass_next = MASS_W'(1);
        end
    end

    // Kick: add the quotient to the velocity with saturation.
    always_comb begin
        sat_res_t r;
        s2_side_next.op   = kd_side.op;
        s2_side_next.idx  = kd_side.idx;
        s2_side_next.pos  = kd_side.pos;
        s2_side_next.vel  = kd_side.vel;
        s2_side_next.sat  = 1'b0;
        s2_side_next.over = 1'b0;
        for (int d = 0; d < DIMS; d++) begin
            r = sat_add(kd_side.vel[d], kq[d], kd_side.neg[d]);
            if (d < 2 || three_dims_reg) begin
                s2_side_next.vel[d] = r.val;
                s2_side_next.sat    = s2_side_next.sat | r.sat;
            end
        end
    end

    // Squares of the active velocity components.
    always_comb begin
        for (int d = 0; d < DIMS; d++) begin
            if (d < 2 || three_dims_reg) begin
                s3_sq_next[d] = WIDE_W'(mag_w(s2_side_reg.vel[d])) *
                                WIDE_W'(mag_w(s2_side_reg.vel[d]));
            end else begin
                s3_sq_next[d] = '0;
            end
        end
    end

    // Limit check against the squared speed limit.
    always_comb begin
        s5_side_next      = s4_side_reg;
        s5_side_next.over = limit_en_reg && (s4_vsq_reg > WIDE_W'(limit_sq_reg));
    end

    // Scale numerator for the limited velocity.
    always_comb begin
        for (int d = 0; d < DIMS; d++) begin
            s6_prod_next[d] = WIDE_W'(mag_w(sq_side.vel[d])) * WIDE_W'(lim_root);
        end
    end

    // Apply the scaled velocity where the limit was exceeded.
    always_comb begin
        s7_side_next = ld_side;
        for (int d = 0; d < DIMS; d++) begin
            if (ld_side.over && (d < 2 || three_dims_reg)) begin
                s7_side_next.vel[d] = ld_side.vel[d][WORD_BITS-1] ?
                                      (~lq[d][WORD_BITS-1:0] + WORD_BITS'(1)) :
                                      lq[d][WORD_BITS-1:0];
            end
        end
    end

    // Drift products.
    always_comb begin
        for (int d = 0; d < DIMS; d++) begin
            s8_dp_next[d] = KPROD_W'(drift_step_reg) * KPROD_W'(mag_w(s7_side_reg.vel[d]));
        end
    end

    // Drift: position update for the initial operation, then pack the result.
    always_comb begin
        sat_res_t r;
        vec_t     pos_n;
        logic     sat_n;
        pos_n = s8_side_reg.pos;
        sat_n = s8_side_reg.sat;
        for (int d = 0; d < DIMS; d++) begin
            r = sat_add(s8_side_reg.pos[d], KPROD_W'(s8_dp_reg[d] >> FRAC_BITS),
                        s8_side_reg.vel[d][WORD_BITS-1]);
            if (!s8_side_reg.op && (d < 2 || three_dims_reg)) begin
                pos_n[d] = r.val;
                sat_n    = sat_n | r.sat;
            end
        end
        m_tdata_next = {s8_side_reg.vel, pos_n, s8_side_reg.idx};
        m_tuser_next = {sat_n, s8_side_reg.over};
    end

    // Stage payload registers.
    always_ff @(posedge aclk) begin
        if (adv) begin
            s0_op_reg   <= s_tuser[0];
            s0_idx_reg  <= s_tdata[15:0];
            s0_type_reg <= type_map[s_tdata[19:16]];
            s0_pos_reg  <= s_tdata[115:20];
            s0_vel_reg  <= s_tdata[211:116];
            s0_frc_reg  <= s_tdata[307:212];

            s1_side_reg  <= s1_side_next;
            s1_mass_reg  <= s1_mass_next;
            s1_kprod_reg <= s1_kprod_next;

            s2_side_reg <= s2_side_next;

            s3_side_reg <= s2_side_reg;
            s3_sq_reg   <= s3_sq_next;

            s4_side_reg <= s3_side_reg;
            s4_vsq_reg  <= s3_sq_reg[0] + s3_sq_reg[1] + s3_sq_reg[2];

            s5_side_reg <= s5_side_next;
            s5_vsq_reg  <= s4_vsq_reg;

            s6_side_reg <= sq_side;
            s6_prod_reg <= s6_prod_next;
            s6_mag_reg  <= (mag_root == '0) ? ROOT_W'(1) : mag_root;

            s7_side_reg <= s7_side_next;

            s8_side_reg <= s7_side_reg;
            s8_dp_reg   <= s8_dp_next;

            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

    // Kick dividers: impulse over mass, one per dimension.
    for (genvar d = 0; d < DIMS; d++) begin : g_kick_div
        vvls_div #(
            .NW (KPROD_W),
            .DW (MASS_W)
        ) u_kick_div (
            .aclk     (aclk),
            .en       (adv),
            .dividend (s1_kprod_reg[d]),
            .divisor  (s1_mass_reg),
            .quotient (kq[d])
        );
    end

    vvls_delay #(
        .W     ($bits(kick_side_t)),
        .DEPTH (KPROD_W)
    ) u_kick_dly (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (s1_valid_reg),
        .in_data   (s1_side_reg),
        .out_valid (kd_valid),
        .out_data  (kd_side)
    );

    // Square roots of the speed squared and of the limit.
    vvls_isqrt #(
        .IW (WIDE_W)
    ) u_mag_sqrt (
        .aclk     (aclk),
        .en       (adv),
        .radicand (s5_vsq_reg),
        .root     (mag_root)
    );

    vvls_isqrt #(
        .IW (WIDE_W)
    ) u_lim_sqrt (
        .aclk     (aclk),
        .en       (adv),
        .radicand (WIDE_W'(limit_sq_reg)),
        .root     (lim_root)
    );

    vvls_delay #(
        .W     ($bits(atom_side_t)),
        .DEPTH (ROOT_W)
    ) u_sqrt_dly (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (s5_valid_reg),
        .in_data   (s5_side_reg),
        .out_valid (sq_valid),
        .out_data  (sq_side)
    );

    // Limit dividers: component times limit over magnitude.
    for (genvar d = 0; d < DIMS; d++) begin : g_lim_div
        vvls_div #(
            .NW (WIDE_W),
            .DW (ROOT_W)
        ) u_lim_div (
            .aclk     (aclk),
            .en       (adv),
            .dividend (s6_prod_reg[d]),
            .divisor  (s6_mag_reg),
            .quotient (lq[d])
        );
    end

    vvls_delay #(
        .W     ($bits(atom_side_t)),
        .DEPTH (WIDE_W)
    ) u_lim_dly (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (s6_valid_reg),
        .in_data   (s6_side_reg),
        .out_valid (ld_valid),
        .out_data  (ld_side)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // A limited result can only come out while limiting is enabled.
    `VVLS_ASSERT_IMPLY(a_limit_needs_enable, aclk, aresetn, m_tvalid_reg && m_tuser_reg[0], limit_en_reg)
    // A held result stops new requests from entering.
    `VVLS_ASSERT_IMPLY(a_backpressure, aclk, aresetn, m_tvalid_reg && !m_tready, !s_tready)
    // A frozen pipeline keeps the item in its last stage before the output register.
    `VVLS_ASSERT_NEXT(a_stall_keeps_item, aclk, aresetn, !adv && s8_valid_reg, s8_valid_reg)

endmodule
